/* src/lmhp_pkg.sv */
// Shared types and constants for the LoRaWAN MAC header parser.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package lmhp_pkg;

  // Frame geometry
  localparam logic [7:0] MAX_FRAME_LEN = 8'd255;
  localparam logic [7:0] MIN_FRAME_LEN = 8'd12;
  localparam logic [7:0] MIC_BYTES     = 8'd4;
  localparam logic [7:0] POS_FCTRL     = 8'd5;
  localparam logic [7:0] POS_FCNT_LO   = 8'd6;
  localparam logic [7:0] POS_FCNT_HI   = 8'd7;
  localparam logic [7:0] POS_FOPTS     = 8'd8;
  localparam logic [7:0] POS_DEVADDR_E = 8'd4;
  localparam logic [3:0] OFFSET_MAX    = 4'd15;

  // Field tag of one byte
  typedef enum logic [3:0] {
    KIND_MHDR    = 4'd0,
    KIND_DEVADDR = 4'd1,
    KIND_FCTRL   = 4'd2,
    KIND_FCNT    = 4'd3,
    KIND_FOPTS   = 4'd4,
    KIND_FPORT   = 4'd5,
    KIND_PAYLOAD = 4'd6,
    KIND_MIC     = 4'd7,
    KIND_DISCARD = 4'd8
  } field_kind_e;

  // Frame status
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_SHORT = 2'd1,
    STAT_OVERRUN   = 2'd2
  } status_e;

  // Parser state carried from byte to byte
  typedef struct packed {
    logic [7:0]  byte_pos;
    logic [7:0]  stored_len;
    logic [7:0]  header_byte;
    logic [7:0]  control_byte;
    logic [15:0] counter_value;
    status_e     error_status;
    logic        in_frame;
  } parse_state_t;

  // One input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] frame_len;
    logic       frame_start;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic [7:0]  byte_value;
    field_kind_e field_kind;
    logic [3:0]  field_offset;
    logic [2:0]  mtype;
    logic [2:0]  rfu_bits;
    logic [1:0]  major;
    logic [3:0]  fctrl_flags;
    logic [3:0]  fopts_len;
    logic [15:0] frame_counter;
    logic        fport_absent;
    logic        frame_done;
    status_e     status;
  } out_word_t;

endpackage

/* src/lmhp_in_if.sv */
// Input byte channel of the MAC header parser: valid/ready plus frame byte.
// Depends on nothing but the handshake convention.
`timescale 1ns / 1ps

interface lmhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [7:0] frame_len;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_len, output frame_start,
                  input ready);
  modport sink   (input valid, input data_byte, input frame_len, input frame_start,
                  output ready);
endinterface

/* src/lmhp_out_if.sv */
// Result channel of the MAC header parser: valid/ready plus tagged byte and
// decoded header fields. Depends on nothing but the handshake convention.
`timescale 1ns / 1ps

interface lmhp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [3:0]  field_kind;
  logic [3:0]  field_offset;
  logic [2:0]  mtype;
  logic [2:0]  rfu_bits;
  logic [1:0]  major;
  logic [3:0]  fctrl_flags;
  logic [3:0]  fopts_len;
  logic [15:0] frame_counter;
  logic        fport_absent;
  logic        frame_done;
  logic [1:0]  status;

  modport source (output valid, output byte_value, output field_kind, output field_offset,
                  output mtype, output rfu_bits, output major, output fctrl_flags,
                  output fopts_len, output frame_counter, output fport_absent,
                  output frame_done, output status, input ready);
  modport sink   (input valid, input byte_value, input field_kind, input field_offset,
                  input mtype, input rfu_bits, input major, input fctrl_flags,
                  input fopts_len, input frame_counter, input fport_absent,
                  input frame_done, input status, output ready);
endinterface

/* src/lmhp_field_decode.sv */
// Per-byte field classifier and header decode (combinational).
// Depends on lmhp_pkg for state, word types and field codes.
`timescale 1ns / 1ps

module lmhp_field_decode (
  input  lmhp_pkg::parse_state_t state_i,
  input  lmhp_pkg::in_word_t     word_i,
  output lmhp_pkg::parse_state_t state_o,
  output lmhp_pkg::out_word_t    result_o
);
  import lmhp_pkg::*;

  parse_state_t st_start;
  parse_state_t st_next;
  field_kind_e  kind;
  logic [3:0]   offset;
  logic         done;
  logic [7:0]   pos;
  logic [7:0]   len;
  logic [8:0]   pos_plus_mic;
  logic [8:0]   mic_off;
  logic [8:0]   fport_pos;
  logic [7:0]   payload_off;
  logic [3:0]   nopt;
  logic         absent;

  // Frame start restarts the parse with cleared header state
  always_comb begin
    st_start = state_i;
    if (word_i.frame_start) begin
      st_start.stored_len    = (word_i.frame_len > MAX_FRAME_LEN) ? MAX_FRAME_LEN
                                                                  : word_i.frame_len;
      st_start.byte_pos      = '0;
      st_start.header_byte   = '0;
      st_start.control_byte  = '0;
      st_start.counter_value = '0;
      st_start.error_status  = (st_start.stored_len < MIN_FRAME_LEN) ? STAT_TOO_SHORT
                                                                     : STAT_OK;
      st_start.in_frame      = 1'b1;
    end
  end

  assign pos          = st_start.byte_pos;
  assign len          = st_start.stored_len;
  assign pos_plus_mic = {1'b0, pos} + {1'b0, MIC_BYTES};
  assign mic_off      = pos_plus_mic - {1'b0, len};
  assign nopt         = st_start.control_byte[3:0];
  assign fport_pos    = {1'b0, POS_FOPTS} + {5'b0, nopt};
  // only used past the FPort byte, where it cannot go negative
  assign payload_off  = pos - POS_FOPTS - 8'd1 - {4'b0, nopt};

  // Tag the byte by position and latch header fields
  always_comb begin
    st_next = st_start;
    kind    = KIND_DISCARD;
    offset  = '0;
    done    = 1'b0;
    if (st_start.in_frame) begin
      if (st_start.error_status == STAT_TOO_SHORT) begin
        kind = KIND_DISCARD;
      end else if (pos_plus_mic >= {1'b0, len}) begin
        kind   = KIND_MIC;
        offset = mic_off[3:0];
      end else if (pos == '0) begin
        st_next.header_byte = word_i.data_byte;
        kind = KIND_MHDR;
      end else if (pos <= POS_DEVADDR_E) begin
        kind   = KIND_DEVADDR;
        offset = 4'(pos - 8'd1);
      end else if (pos == POS_FCTRL) begin
        st_next.control_byte = word_i.data_byte;
        kind = KIND_FCTRL;
        if ({4'b0, word_i.data_byte[3:0]} > (len - MIN_FRAME_LEN)) begin
          st_next.error_status = STAT_OVERRUN;
        end
      end else if (pos <= POS_FCNT_HI) begin
        kind = KIND_FCNT;
        if (pos == POS_FCNT_LO) begin
          offset = 4'd0;
          st_next.counter_value[7:0] = word_i.data_byte;
        end else begin
          offset = 4'd1;
          st_next.counter_value[15:8] = word_i.data_byte;
        end
      end else if (st_start.error_status == STAT_OVERRUN) begin
        kind = KIND_DISCARD;
      end else if ({1'b0, pos} < fport_pos) begin
        kind   = KIND_FOPTS;
        offset = 4'(pos - POS_FOPTS);
      end else if ({1'b0, pos} == fport_pos) begin
        kind = KIND_FPORT;
      end else begin
        kind   = KIND_PAYLOAD;
        offset = (payload_off > {4'b0, OFFSET_MAX}) ? OFFSET_MAX : payload_off[3:0];
      end
      st_next.byte_pos = pos + 8'd1;
      if (({1'b0, pos} + 9'd1) >= {1'b0, len}) begin
        done             = 1'b1;
        st_next.in_frame = 1'b0;
      end
    end
  end

  // FPort missing: exactly zero bytes between options and MIC
  assign absent = (st_next.error_status == STAT_OK) && (st_next.byte_pos >= POS_FCNT_LO) &&
                  (st_next.stored_len == (MIN_FRAME_LEN + {4'b0, st_next.control_byte[3:0]}));

  assign state_o = st_next;

  always_comb begin
    result_o.byte_value    = word_i.data_byte;
    result_o.field_kind    = kind;
    result_o.field_offset  = offset;
    result_o.mtype         = st_next.header_byte[7:5];
    result_o.rfu_bits      = st_next.header_byte[4:2];
    result_o.major         = st_next.header_byte[1:0];
    result_o.fctrl_flags   = st_next.control_byte[7:4];
    result_o.fopts_len     = st_next.control_byte[3:0];
    result_o.frame_counter = st_next.counter_value;
    result_o.fport_absent  = absent;
    result_o.frame_done    = done;
    result_o.status        = st_next.error_status;
  end

endmodule

/* src/lorawan_mac_header_parser.sv */
// Top level of the LoRaWAN MAC header parser: input register, decode, result register.
// Depends on lmhp_pkg, lmhp_in_if, lmhp_out_if and lmhp_field_decode.
//
//   channel | dir | word contents
//   --------+-----+--------------------------------------------------------------
//   in_i    | in  | data_byte, frame_len, frame_start
//   out_o   | out | byte_value, field tag and offset, decoded MHDR/FCtrl/FCnt, status
//
// One byte per cycle sustained unless out_o stalls; an accepted byte passes the input register
// and then the result register before it is offered. The parser state updates only as a byte
// moves from input to result register: one classify/decode pass per cycle unless out_o stalls.
// Reset clears the parser state and both valid flags; frames restart on frame_start.
// A stalled result holds the input register, and in_i.ready drops once both are full.
`timescale 1ns / 1ps

module lorawan_mac_header_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  lmhp_in_if.sink          in_i,
  lmhp_out_if.source       out_o
);
  import lmhp_pkg::*;

  logic         in_valid_q;
  in_word_t     in_word_q;
  logic         out_valid_q;
  out_word_t    out_word_q;
  logic         advance;
  parse_state_t state_q;
  parse_state_t state_d;
  out_word_t    result;
  in_word_t     in_word;

  // Input register moves on whenever the result register is free or draining
  assign advance    = ~out_valid_q | out_o.ready;
  assign in_i.ready = ~in_valid_q | advance;

  assign in_word.data_byte   = in_i.data_byte;
  assign in_word.frame_len   = in_i.frame_len;
  assign in_word.frame_start = in_i.frame_start;

  lmhp_field_decode u_decode (
    .state_i  (state_q),
    .word_i   (in_word_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_word_q <= in_word;
    end
  end

  // Parser state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_word_q <= result;
    end
  end

  // Result port
  assign out_o.valid         = out_valid_q;
  assign out_o.byte_value    = out_word_q.byte_value;
  assign out_o.field_kind    = out_word_q.field_kind;
  assign out_o.field_offset  = out_word_q.field_offset;
  assign out_o.mtype         = out_word_q.mtype;
  assign out_o.rfu_bits      = out_word_q.rfu_bits;
  assign out_o.major         = out_word_q.major;
  assign out_o.fctrl_flags   = out_word_q.fctrl_flags;
  assign out_o.fopts_len     = out_word_q.fopts_len;
  assign out_o.frame_counter = out_word_q.frame_counter;
  assign out_o.fport_absent  = out_word_q.fport_absent;
  assign out_o.frame_done    = out_word_q.frame_done;
  assign out_o.status        = out_word_q.status;

`ifndef ASSERT_OFF
  // short frames never get a field tag
  a_short_discard : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_word_q.status == STAT_TOO_SHORT) |->
      (out_word_q.field_kind == KIND_DISCARD))
    else $error("too-short frame byte was tagged");

  // the last byte of a long enough frame is always MIC
  a_done_is_mic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.frame_done && (out_word_q.status != STAT_TOO_SHORT) |->
      (out_word_q.field_kind == KIND_MIC))
    else $error("frame ended on a non-MIC byte");

  // discarded bytes carry no offset
  a_discard_off : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_word_q.field_kind == KIND_DISCARD) |->
      (out_word_q.field_offset == '0))
    else $error("discarded byte with nonzero offset");

  // missing FPort is only reported for a good frame
  a_absent_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.fport_absent |-> (out_word_q.status == STAT_OK))
    else $error("fport_absent with bad status");

  // a held input word stays put while the result register is blocked
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_word_q))
    else $error("input register changed under stall");
`endif

endmodule
